/* hw/rtl/lsp_pkg.sv */
// ----------------------------------------------------------------------------
// Plane fit package
// Shared types, constants and helper functions of the least-squares plane fit.
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int SUM_W      = 64;
	localparam int WIDE_W     = 256;

	// Datapath operations issued by the controller.
	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_CLRTOT  = 4'd1;
	localparam logic [3:0] OP_LOAD    = 4'd2;
	localparam logic [3:0] OP_MULINIT = 4'd3;
	localparam logic [3:0] OP_MULSTEP = 4'd4;
	localparam logic [3:0] OP_MULEND  = 4'd5;
	localparam logic [3:0] OP_ACCUM   = 4'd6;
	localparam logic [3:0] OP_SAVEDET = 4'd7;
	localparam logic [3:0] OP_DIVABS  = 4'd8;
	localparam logic [3:0] OP_DIVINIT = 4'd9;
	localparam logic [3:0] OP_DIVSTEP = 4'd10;
	localparam logic [3:0] OP_DIVEND  = 4'd11;
	localparam logic [3:0] OP_FINISH  = 4'd12;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SINGULAR  = 2'd1;
	localparam logic [1:0] ST_SATURATED = 2'd2;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0] coef_const;
		logic signed [31:0] coef_x;
		logic signed [31:0] coef_y;
		logic [1:0]         fit_status;
	} fit_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] mat;
		logic [1:0] row;
		logic [1:0] col;
		logic       neg;
		logic       mul_last;
		logic       sh16;
		logic [1:0] coef_idx;
		logic       singular;
		logic       busy;
	} cmd_t;

	typedef struct packed {
		logic last_done;
		logic det_zero;
		logic out_full;
	} status_t;

	// Column picked in each row by the six terms of the Leibniz expansion.
	function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] row);
		logic [5:0] cols;
		case (t)
			3'd0:    cols = {2'd0, 2'd1, 2'd2};
			3'd1:    cols = {2'd0, 2'd2, 2'd1};
			3'd2:    cols = {2'd1, 2'd0, 2'd2};
			3'd3:    cols = {2'd1, 2'd2, 2'd0};
			3'd4:    cols = {2'd2, 2'd0, 2'd1};
			default: cols = {2'd2, 2'd1, 2'd0};
		endcase
		case (row)
			2'd0:    return cols[5:4];
			2'd1:    return cols[3:2];
			default: return cols[1:0];
		endcase
	endfunction

	function automatic logic perm_neg(input logic [2:0] t);
		return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
	endfunction

endpackage

/* hw/rtl/least_squares_plane_fit_unit.sv */
// Points are taken one per cycle while point_stall is low; sums update from a
// registered stage. A point marked last starts the solve, which ends early for
// a singular set; the 64-step multiplier and 256-step divider set its length.
// Points are stalled during the solve; the next set may start while the result waits.
// Asynchronous active-low reset clears the count, the sums and all control state.
// ----------------------------------------------------------------------------
// Least-squares plane fit unit
// Accumulates the normal equations and solves them by Cramer's rule.
// ----------------------------------------------------------------------------
module least_squares_plane_fit_unit import lsp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   point_valid,
	output logic   point_stall,
	input  point_t point,
	output logic   fit_valid,
	input  logic   fit_stall,
	output fit_t   fit
);

	cmd_t    cmd;
	status_t status;

	lsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	lsp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.fit_valid   (fit_valid),
		.fit_stall   (fit_stall),
		.fit         (fit)
	);

endmodule

/* hw/rtl/lsp_ctrl.sv */
// ----------------------------------------------------------------------------
// Plane fit controller
// Sequences the determinant expansions, the shift-add multiplies and the
// restoring divisions of the solve.
// ----------------------------------------------------------------------------
module lsp_ctrl import lsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WOUT  = 4'd1;
	localparam logic [3:0] S_CLR   = 4'd2;
	localparam logic [3:0] S_LOAD  = 4'd3;
	localparam logic [3:0] S_MINIT = 4'd4;
	localparam logic [3:0] S_MSTEP = 4'd5;
	localparam logic [3:0] S_MEND  = 4'd6;
	localparam logic [3:0] S_ACC   = 4'd7;
	localparam logic [3:0] S_SAVE  = 4'd8;
	localparam logic [3:0] S_CHK   = 4'd9;
	localparam logic [3:0] S_DABS  = 4'd10;
	localparam logic [3:0] S_DINIT = 4'd11;
	localparam logic [3:0] S_DSTEP = 4'd12;
	localparam logic [3:0] S_DEND  = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	logic [3:0] state_q;
	logic [1:0] mat_q;
	logic [2:0] term_q;
	logic [1:0] mrow_q;
	logic [7:0] bit_q;
	logic       sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mat_q   <= 2'd0;
			term_q  <= 3'd0;
			mrow_q  <= 2'd1;
			bit_q   <= 8'd0;
			sing_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (status.last_done) state_q <= S_WOUT;
				end
				S_WOUT: begin
					if (!status.out_full) begin
						mat_q   <= 2'd0;
						sing_q  <= 1'b0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					term_q  <= 3'd0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					mrow_q  <= 2'd1;
					state_q <= S_MINIT;
				end
				S_MINIT: begin
					bit_q   <= 8'd0;
					state_q <= S_MSTEP;
				end
				S_MSTEP: begin
					bit_q <= bit_q + 8'd1;
					if (bit_q == 8'd63) state_q <= S_MEND;
				end
				S_MEND: begin
					if (mrow_q == 2'd1) begin
						mrow_q  <= 2'd2;
						state_q <= S_MINIT;
					end else begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (term_q == 3'd5) begin
						state_q <= (mat_q == 2'd0) ? S_SAVE : S_DABS;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= S_LOAD;
					end
				end
				S_SAVE: state_q <= S_CHK;
				S_CHK: begin
					if (status.det_zero) begin
						sing_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						mat_q   <= 2'd1;
						state_q <= S_CLR;
					end
				end
				S_DABS:  state_q <= S_DINIT;
				S_DINIT: begin
					bit_q   <= 8'd0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					bit_q <= bit_q + 8'd1;
					if (bit_q == 8'd255) state_q <= S_DEND;
				end
				S_DEND: begin
					if (mat_q == 2'd3) begin
						state_q <= S_FIN;
					end else begin
						mat_q   <= mat_q + 2'd1;
						state_q <= S_CLR;
					end
				end
				S_FIN:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.mat      = mat_q;
		cmd.neg      = perm_neg(term_q);
		cmd.mul_last = (bit_q == 8'd63);
		cmd.sh16     = (mat_q != 2'd1);
		cmd.coef_idx = mat_q - 2'd1;
		cmd.singular = sing_q;
		cmd.busy     = (state_q != S_IDLE);
		cmd.row      = mrow_q;
		cmd.col      = perm_col(term_q, mrow_q);
		case (state_q)
			S_CLR:   cmd.op = OP_CLRTOT;
			S_LOAD: begin
				cmd.op  = OP_LOAD;
				cmd.row = 2'd0;
				cmd.col = perm_col(term_q, 2'd0);
			end
			S_MINIT: cmd.op = OP_MULINIT;
			S_MSTEP: cmd.op = OP_MULSTEP;
			S_MEND:  cmd.op = OP_MULEND;
			S_ACC:   cmd.op = OP_ACCUM;
			S_SAVE:  cmd.op = OP_SAVEDET;
			S_DABS:  cmd.op = OP_DIVABS;
			S_DINIT: cmd.op = OP_DIVINIT;
			S_DSTEP: cmd.op = OP_DIVSTEP;
			S_DEND:  cmd.op = OP_DIVEND;
			S_FIN:   cmd.op = OP_FINISH;
			default: cmd.op = OP_NOP;
		endcase
	end

endmodule

/* hw/rtl/lsp_datapath.sv */
// ----------------------------------------------------------------------------
// Plane fit datapath
// Point accumulation, 256-bit shift-add multiplier, restoring divider and
// the output register.
// ----------------------------------------------------------------------------
module lsp_datapath import lsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output status_t status,
	input  logic    point_valid,
	output logic    point_stall,
	input  point_t  point,
	output logic    fit_valid,
	input  logic    fit_stall,
	output fit_t    fit
);

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
	                                             input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = a + b;
		if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1]))
			return a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return s;
	endfunction

	// Accumulation stage
	logic                    v_s1, last_s1;
	logic signed [31:0]      x_s1, y_s1, z_s1;
	logic signed [SUM_W-1:0] xx_s1, yy_s1, xy_s1, zx_s1, zy_s1;

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sx_q, sy_q, sz_q, sxx_q, syy_q, sxy_q, szx_q, szy_q;

	logic accept;
	assign point_stall = cmd.busy | (v_s1 & last_s1);
	assign accept      = point_valid & ~point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= accept;
			last_s1 <= accept & point.last_point;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= point.point_x;
			y_s1  <= point.point_y;
			z_s1  <= point.point_z;
			xx_s1 <= point.point_x * point.point_x;
			yy_s1 <= point.point_y * point.point_y;
			xy_s1 <= point.point_x * point.point_y;
			zx_s1 <= point.point_z * point.point_x;
			zy_s1 <= point.point_z * point.point_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			szx_q   <= '0;
			szy_q   <= '0;
		end else if (cmd.op == OP_FINISH) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			szx_q   <= '0;
			szy_q   <= '0;
		end else if (v_s1 && (count_q < CNT_W'(MAX_POINTS))) begin
			count_q <= count_q + 1'b1;
			sx_q    <= sat_add(sx_q, SUM_W'(x_s1));
			sy_q    <= sat_add(sy_q, SUM_W'(y_s1));
			sz_q    <= sat_add(sz_q, SUM_W'(z_s1));
			sxx_q   <= sat_add(sxx_q, xx_s1);
			syy_q   <= sat_add(syy_q, yy_s1);
			sxy_q   <= sat_add(sxy_q, xy_s1);
			szx_q   <= sat_add(szx_q, zx_s1);
			szy_q   <= sat_add(szy_q, zy_s1);
		end
	end

	// Matrix entry selection; a numerator matrix has one column replaced.
	logic [SUM_W-1:0] ent;
	always_comb begin
		logic [SUM_W-1:0] mval, vval;
		case ({cmd.row, cmd.col})
			4'b0000: mval = {{(SUM_W-CNT_W){1'b0}}, count_q};
			4'b0001: mval = sx_q;
			4'b0010: mval = sy_q;
			4'b0100: mval = sx_q;
			4'b0101: mval = sxx_q;
			4'b0110: mval = sxy_q;
			4'b1000: mval = sy_q;
			4'b1001: mval = sxy_q;
			default: mval = syy_q;
		endcase
		case (cmd.row)
			2'd0:    vval = sz_q;
			2'd1:    vval = szx_q;
			default: vval = szy_q;
		endcase
		ent = ((cmd.mat != 2'd0) && (cmd.col == cmd.mat - 2'd1)) ? vval : mval;
	end

	// Solve registers
	logic [WIDE_W-1:0] acc_q, mula_q, prod_q, tot_q, det_q;
	logic [SUM_W-1:0]  mulb_q;
	logic [WIDE_W-1:0] an_q, ad_q, dnum_q, den_q, rem_q, quo_q;
	logic              neg_q, sat_q;
	logic [31:0]       coef_q [3];

	logic [WIDE_W-1:0] num_sel, rem_sh;
	logic [31:0]       q_lo;
	logic              q_big;
	assign num_sel = cmd.sh16 ? {tot_q[WIDE_W-17:0], 16'd0} : tot_q;
	assign rem_sh  = {rem_q[WIDE_W-2:0], dnum_q[WIDE_W-1]};
	assign q_lo    = quo_q[31:0];
	assign q_big   = |quo_q[WIDE_W-1:32];

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CLRTOT: tot_q <= '0;
			OP_LOAD:   acc_q <= {{(WIDE_W-SUM_W){ent[SUM_W-1]}}, ent};
			OP_MULINIT: begin
				mula_q <= acc_q;
				mulb_q <= ent;
				prod_q <= '0;
			end
			OP_MULSTEP: begin
				// The top multiplier bit carries negative weight.
				if (mulb_q[0]) prod_q <= cmd.mul_last ? prod_q - mula_q : prod_q + mula_q;
				mula_q <= {mula_q[WIDE_W-2:0], 1'b0};
				mulb_q <= {1'b0, mulb_q[SUM_W-1:1]};
			end
			OP_MULEND: acc_q <= prod_q;
			OP_ACCUM:  tot_q <= cmd.neg ? tot_q - acc_q : tot_q + acc_q;
			OP_SAVEDET: begin
				det_q  <= tot_q;
				sat_q  <= 1'b0;
			end
			OP_DIVABS: begin
				neg_q <= num_sel[WIDE_W-1] ^ det_q[WIDE_W-1];
				an_q  <= num_sel[WIDE_W-1] ? -num_sel : num_sel;
				ad_q  <= det_q[WIDE_W-1] ? -det_q : det_q;
			end
			OP_DIVINIT: begin
				// Rounding to nearest: (2|n| + |d|) / (2|d|).
				dnum_q <= {an_q[WIDE_W-2:0], 1'b0} + ad_q;
				den_q  <= {ad_q[WIDE_W-2:0], 1'b0};
				rem_q  <= '0;
				quo_q  <= '0;
			end
			OP_DIVSTEP: begin
				dnum_q <= {dnum_q[WIDE_W-2:0], 1'b0};
				if (rem_sh >= den_q) begin
					rem_q <= rem_sh - den_q;
					quo_q <= {quo_q[WIDE_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[WIDE_W-2:0], 1'b0};
				end
			end
			OP_DIVEND: begin
				if (neg_q) begin
					if (q_big || (q_lo > 32'h8000_0000)) begin
						coef_q[cmd.coef_idx] <= 32'h8000_0000;
						sat_q                <= 1'b1;
					end else begin
						coef_q[cmd.coef_idx] <= 32'd0 - q_lo;
					end
				end else begin
					if (q_big || q_lo[31]) begin
						coef_q[cmd.coef_idx] <= 32'h7fff_ffff;
						sat_q                <= 1'b1;
					end else begin
						coef_q[cmd.coef_idx] <= q_lo;
					end
				end
			end
			default: ;
		endcase
	end

	// Output register
	logic fit_valid_q;
	fit_t fit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_valid_q <= 1'b0;
		end else if (cmd.op == OP_FINISH) begin
			fit_valid_q <= 1'b1;
		end else if (!fit_stall) begin
			fit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINISH) begin
			if (cmd.singular) begin
				fit_q.coef_const <= '0;
				fit_q.coef_x     <= '0;
				fit_q.coef_y     <= '0;
				fit_q.fit_status <= ST_SINGULAR;
			end else begin
				fit_q.coef_const <= coef_q[0];
				fit_q.coef_x     <= coef_q[1];
				fit_q.coef_y     <= coef_q[2];
				fit_q.fit_status <= sat_q ? ST_SATURATED : ST_OK;
			end
		end
	end

	assign fit_valid        = fit_valid_q;
	assign fit              = fit_q;
	assign status.last_done = v_s1 & last_s1;
	assign status.det_zero  = (det_q == '0);
	assign status.out_full  = fit_valid_q;

endmodule

/* hw/rtl/lsp_checker.sv */
// ----------------------------------------------------------------------------
// Plane fit checker
// Port-level assertions on the point and result channels.
// ----------------------------------------------------------------------------
module lsp_checker import lsp_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   point_valid,
	input logic   point_stall,
	input point_t point,
	input logic   fit_valid,
	input logic   fit_stall,
	input fit_t   fit
);

	// A point marked last blocks further points while the solve starts.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && point.last_point |=> point_stall)
		else $error("point accepted right after a last point");

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid && fit_stall |=> fit_valid && $stable(fit))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid |-> fit.fit_status != 2'd3)
		else $error("undefined fit status");

	assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid && fit.fit_status == ST_SINGULAR |->
			fit.coef_const == 0 && fit.coef_x == 0 && fit.coef_y == 0)
		else $error("singular result with nonzero coefficients");

	// Saturation is only reported when some coefficient sits at a limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid && fit.fit_status == ST_SATURATED |->
			fit.coef_const == 32'h7fff_ffff || fit.coef_const == 32'h8000_0000 ||
			fit.coef_x == 32'h7fff_ffff || fit.coef_x == 32'h8000_0000 ||
			fit.coef_y == 32'h7fff_ffff || fit.coef_y == 32'h8000_0000)
		else $error("saturated status without clamped coefficient");

endmodule

bind least_squares_plane_fit_unit lsp_checker u_lsp_checker (.*);
